// ===== rtl/bae_pkg.sv =====
// Shared types and constants for the bounded array engine.
`default_nettype none
package bae_pkg;

  // Number of cells in the row; fixed by the 4-bit position field.
  localparam int unsigned CAP   = 16;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SET    = 3'd2,
    OP_DEL    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_READ   = 3'd5,
    OP_FIND   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Broadcast command from the sequencer to the cell row.
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] waddr;
    logic             shift;
    logic [IDX_W-1:0] sbase;
    logic             cmp;
  } cell_cmd_t;

  // Per-cell enables decoded from the broadcast command.
  typedef struct packed {
    logic wr_en;
    logic shift_en;
    logic cmp_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/bae_cell.sv =====
// One list cell: holds an entry and its match flag, shifts down from its neighbor.
`default_nettype none
module bae_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                      clk,
  input  bae_pkg::cell_ctl_t       ctl,
  input  wire  [DATA_WIDTH-1:0]    wr_data,
  input  wire  [DATA_WIDTH-1:0]    shift_data,
  input  wire                      shift_match,
  output logic [DATA_WIDTH-1:0]    entry,
  output logic                     match
);

  logic [DATA_WIDTH-1:0] entry_r;
  logic                  match_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_r <= wr_data;
    end else if (ctl.shift_en) begin
      entry_r <= shift_data;
    end
  end

  // compare value arrives on the write bus
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= (entry_r == wr_data);
    end else if (ctl.shift_en) begin
      match_r <= shift_match;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

// ===== rtl/bae_ctrl.sv =====
// Sequencer: fill count, operation decode, match scan and result register.
`default_nettype none
module bae_ctrl #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [2:0]                       op,
  input  wire  [bae_pkg::IDX_W-1:0]        pos,
  input  wire  [DATA_WIDTH-1:0]            rd_data,
  input  wire  [bae_pkg::CAP-1:0]          match_vec,
  output logic [bae_pkg::IDX_W-1:0]        rd_addr,
  output bae_pkg::cell_cmd_t               cmd,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [DATA_WIDTH-1:0]            out_data,
  output logic [bae_pkg::IDX_W-1:0]        out_index,
  output logic [2:0]                       out_status,
  output logic [bae_pkg::CNT_W-1:0]        out_count,
  output logic                             out_empty
);

  bae_pkg::state_t              state_r, state_nxt;
  bae_pkg::op_t                 op_r;
  bae_pkg::op_t                 op_in;
  logic [bae_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         removed_r, removed_nxt;
  logic                         accept;
  logic                         load;
  logic                         out_vld_r;
  logic [DATA_WIDTH-1:0]        data_r, data_nxt;
  logic [bae_pkg::IDX_W-1:0]    index_r, index_nxt;
  bae_pkg::status_t             status_r, status_nxt;
  logic [bae_pkg::CNT_W-1:0]    ocnt_r;
  logic                         empty_r;
  logic [bae_pkg::CAP-1:0]      live;
  logic [bae_pkg::CAP-1:0]      hit;
  logic                         any_hit;
  logic [bae_pkg::IDX_W-1:0]    first_hit;
  logic                         pos_bad;

  assign op_in    = bae_pkg::op_t'(op);
  assign in_ready = (state_r == bae_pkg::S_IDLE) && (!out_vld_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign pos_bad  = ({1'b0, pos} >= cnt_r);
  assign rd_addr  = (op_in == bae_pkg::OP_POP) ? bae_pkg::IDX_W'(cnt_r - 1'b1) : pos;

  // live cells and lowest live match
  always_comb begin
    for (int i = 0; i < bae_pkg::CAP; i++) begin
      live[i] = (bae_pkg::CNT_W'(i) < cnt_r);
    end
    hit       = match_vec & live;
    any_hit   = |hit;
    first_hit = '0;
    for (int i = bae_pkg::CAP - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_hit = bae_pkg::IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bae_pkg::S_IDLE: begin
        if (accept && (op_in == bae_pkg::OP_REMOVE || op_in == bae_pkg::OP_FIND)) begin
          state_nxt = bae_pkg::S_SCAN;
        end
      end
      bae_pkg::S_SCAN: begin
        if (op_r != bae_pkg::OP_REMOVE || !any_hit) begin
          state_nxt = bae_pkg::S_IDLE;
        end
      end
      default: state_nxt = bae_pkg::S_IDLE;
    endcase
  end

  // outputs: cell commands, count update, result load
  always_comb begin
    cmd         = '0;
    cnt_nxt     = cnt_r;
    removed_nxt = removed_r;
    load        = 1'b0;
    data_nxt    = '0;
    index_nxt   = '0;
    status_nxt  = bae_pkg::ST_OK;
    case (state_r)
      bae_pkg::S_IDLE: begin
        if (accept) begin
          load        = 1'b1;
          removed_nxt = 1'b0;
          case (op_in)
            bae_pkg::OP_PUSH: begin
              if (cnt_r == bae_pkg::CNT_W'(bae_pkg::CAP)) begin
                status_nxt = bae_pkg::ST_FULL;
              end else begin
                cmd.wr    = 1'b1;
                cmd.waddr = cnt_r[bae_pkg::IDX_W-1:0];
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            bae_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt = bae_pkg::ST_EMPTY;
              end else begin
                data_nxt = rd_data;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            bae_pkg::OP_SET: begin
              if (pos_bad) begin
                status_nxt = bae_pkg::ST_BADPOS;
              end else begin
                cmd.wr    = 1'b1;
                cmd.waddr = pos;
              end
            end
            bae_pkg::OP_DEL: begin
              if (pos_bad) begin
                status_nxt = bae_pkg::ST_BADPOS;
              end else begin
                cmd.shift = 1'b1;
                cmd.sbase = pos;
                cnt_nxt   = cnt_r - 1'b1;
              end
            end
            bae_pkg::OP_READ: begin
              if (pos_bad) begin
                status_nxt = bae_pkg::ST_BADPOS;
              end else begin
                data_nxt = rd_data;
              end
            end
            bae_pkg::OP_REMOVE, bae_pkg::OP_FIND: begin
              // latch match flags, answer comes from the scan
              cmd.cmp = 1'b1;
              load    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      bae_pkg::S_SCAN: begin
        if (op_r == bae_pkg::OP_REMOVE) begin
          if (any_hit) begin
            cmd.shift   = 1'b1;
            cmd.sbase   = first_hit;
            cnt_nxt     = cnt_r - 1'b1;
            removed_nxt = 1'b1;
          end else begin
            load       = 1'b1;
            status_nxt = removed_r ? bae_pkg::ST_OK : bae_pkg::ST_NOTFOUND;
          end
        end else begin
          load       = 1'b1;
          index_nxt  = any_hit ? first_hit : '0;
          status_nxt = any_hit ? bae_pkg::ST_OK : bae_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bae_pkg::S_IDLE;
      cnt_r     <= '0;
      removed_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      removed_r <= removed_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_in;
    end
    if (load) begin
      data_r   <= data_nxt;
      index_r  <= index_nxt;
      status_r <= status_nxt;
      ocnt_r   <= cnt_nxt;
      empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_valid  = out_vld_r;
  assign out_data   = data_r;
  assign out_index  = index_r;
  assign out_status = status_r;
  assign out_count  = ocnt_r;
  assign out_empty  = empty_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bae_pkg::CNT_W'(bae_pkg::CAP))
    else $error("fill count above capacity");

  a_scan_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bae_pkg::S_SCAN |-> !out_vld_r)
    else $error("result slot busy during scan");

  a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::S_SCAN && op_r == bae_pkg::OP_REMOVE && any_hit)
    |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("remove step did not shrink the list");

  a_find_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::S_SCAN && op_r == bae_pkg::OP_FIND)
    |=> state_r == bae_pkg::S_IDLE && out_vld_r)
    else $error("find did not finish in one scan cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (empty_r == (ocnt_r == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule
`default_nettype wire

// ===== rtl/bounded_array_engine.sv =====
// Top level: packed list held in a row of shifting cells with a scan sequencer.
//
//  channel | direction | tdata fields (low bit first)                      | width
//  in_     | slave     | op[2:0] position[6:3] value[38:7], pad            | 40
//  out_    | master    | data[31:0] index[35:32] status[38:36]             | 48
//          |           | count[43:39] empty_res[44], pad                   |
//
//  Push, pop, set, delete at, read and the unused code finish on acceptance:
//  the cell row writes or shifts in place and the result is registered in the
//  same cycle. Find compares into per-cell match flags, then does one scan.
//  Remove compares the same way, then each scan step shifts the row down over
//  the lowest live match, flags travel along, until no live match is left.
//  One item is in flight at a time; a new item is taken while the previous
//  result is being drained. Reset (rst_n low, synchronous) clears the fill
//  count and handshake state only; cell contents stay unknown until written.
`default_nettype none
module bounded_array_engine #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // op[2:0], position[6:3], value[38:7], zero pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // data, index, status, count, empty_res, zero pad
);

  localparam int unsigned CAP = bae_pkg::CAP;

  logic [2:0]                  in_op;
  logic [bae_pkg::IDX_W-1:0]   in_pos;
  logic [31:0]                 in_value;
  logic [DATA_WIDTH-1:0]       val_dw;

  logic [DATA_WIDTH-1:0]       entry_w [CAP];
  logic [CAP-1:0]              match_w;
  logic [bae_pkg::IDX_W-1:0]   rd_addr;
  logic [DATA_WIDTH-1:0]       rd_data;
  bae_pkg::cell_cmd_t          cmd;

  logic [DATA_WIDTH-1:0]       res_data;
  logic [31:0]                 res_data32;
  logic [bae_pkg::IDX_W-1:0]   res_index;
  logic [2:0]                  res_status;
  logic [bae_pkg::CNT_W-1:0]   res_count;
  logic                        res_empty;

  assign in_op    = in_tdata[2:0];
  assign in_pos   = in_tdata[6:3];
  assign in_value = in_tdata[38:7];

  // value taken modulo 2^DATA_WIDTH; result data zero-extended or cut to the 32-bit field
  generate
    if (DATA_WIDTH <= 32) begin : g_narrow
      assign val_dw     = in_value[DATA_WIDTH-1:0];
      assign res_data32 = 32'(res_data);
    end else begin : g_wide
      assign val_dw     = DATA_WIDTH'(in_value);
      assign res_data32 = res_data[31:0];
    end
  endgenerate

  // cell row: cell i shifts in from cell i+1 when at or above the shift base
  generate
    for (genvar i = 0; i < CAP; i++) begin : g_cell
      bae_pkg::cell_ctl_t    ctl;
      logic [DATA_WIDTH-1:0] up_data;
      logic                  up_match;

      assign ctl.wr_en    = cmd.wr && (cmd.waddr == bae_pkg::IDX_W'(i));
      assign ctl.shift_en = cmd.shift && (bae_pkg::IDX_W'(i) >= cmd.sbase);
      assign ctl.cmp_en   = cmd.cmp;

      if (i == CAP - 1) begin : g_tail
        assign up_data  = '0;
        assign up_match = 1'b0;
      end else begin : g_link
        assign up_data  = entry_w[i+1];
        assign up_match = match_w[i+1];
      end

      bae_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .wr_data     (val_dw),
        .shift_data  (up_data),
        .shift_match (up_match),
        .entry       (entry_w[i]),
        .match       (match_w[i])
      );
    end
  endgenerate

  // single read port for pop and read
  assign rd_data = entry_w[rd_addr];

  bae_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (in_op),
    .pos        (in_pos),
    .rd_data    (rd_data),
    .match_vec  (match_w),
    .rd_addr    (rd_addr),
    .cmd        (cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (res_data),
    .out_index  (res_index),
    .out_status (res_status),
    .out_count  (res_count),
    .out_empty  (res_empty)
  );

  assign out_tdata = {3'b000, res_empty, res_count, res_status, res_index, res_data32};

endmodule
`default_nettype wire
